// ===== src/tleb_pkg.sv =====
// Shared widths, codes and defaults of the terminal line edit buffer.
package tleb_pkg;

  localparam int COL_W        = 11;  // column, count and length width
  localparam int CHAR_W       = 8;   // one stored character
  localparam int LEN_CMP_W    = 13;  // wide enough to compare against any line depth
  localparam int MAX_COLS_DEF = 2048;

  localparam logic [COL_W-1:0] LINE_LEN_RST = 11'd80;

  // Request function codes.
  localparam logic [1:0] FN_CHAR    = 2'd0;
  localparam logic [1:0] FN_SPECIAL = 2'd1;
  localparam logic [1:0] FN_CLEAR   = 2'd2;
  localparam logic [1:0] FN_READ    = 2'd3;

  // Character key bytes with an editing meaning.
  localparam logic [CHAR_W-1:0] KEY_HOME  = 8'd1;
  localparam logic [CHAR_W-1:0] KEY_END   = 8'd5;
  localparam logic [CHAR_W-1:0] KEY_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] KEY_ENTER = 8'd10;
  localparam logic [CHAR_W-1:0] KEY_DEL   = 8'd127;

  // Printable range and the padding character.
  localparam logic [CHAR_W-1:0] CH_FIRST = 8'h20;
  localparam logic [CHAR_W-1:0] CH_LAST  = 8'h7E;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_NONE  = 8'h00;

  // Special key codes.
  localparam logic [CHAR_W-1:0] SP_HOME  = 8'd0;
  localparam logic [CHAR_W-1:0] SP_END   = 8'd1;
  localparam logic [CHAR_W-1:0] SP_LEFT  = 8'd2;
  localparam logic [CHAR_W-1:0] SP_RIGHT = 8'd3;

endpackage

// ===== src/tleb_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module tleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/terminal_line_edit_buffer_top.sv =====
// Top level of the terminal line edit buffer: control, state registers and line store.
//
// The block keeps one line of text in overwrite mode and takes decoded keystrokes.
// Input channel (in_valid / in_stall): one request carries in_func, in_key_code and
// in_read_index; it is taken at a clock edge with in_valid high and in_stall low.
// Result channel (out_valid / out_stall): exactly one result per request, held
// stable while out_stall is high; a finished result may wait there while the
// next request is already taken and worked on.
// Configuration (cfg_valid / cfg_ready, cfg_line_length): writing the line length
// also starts a new, empty line. Write it only while no request is in flight.
// Request path: cursor moves, Enter, clear and overwrite pass ST_IDLE and ST_FIN to
// the result register; a read also passes ST_READ. Backspace and Delete move the text tail
// left in ST_SHIFT through the line store's single read and write port, one character per
// cycle. The block takes one request at a time.
// Reset clears cursor, text count and done flag and sets the line length to 80.
// The line store itself needs no clearing pass: columns at or beyond the text
// count read as spaces, or as zero past the store, so stale cells are never seen.
// While out_stall holds a result, the block finishes the current request and
// then waits with in_stall high until the result register frees up.
module terminal_line_edit_buffer_top
  import tleb_pkg::*;
#(
  parameter int MAX_COLS = MAX_COLS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  // Request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_func,
  input  logic [CHAR_W-1:0] in_key_code,
  input  logic [COL_W-1:0]  in_read_index,
  // Result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [COL_W-1:0]  out_text_count,
  output logic              out_line_done,
  output logic              out_edited,
  output logic [CHAR_W-1:0] out_read_char,
  // Configuration write channel
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [COL_W-1:0]  cfg_line_length
);

  localparam int AW = $clog2(MAX_COLS);
  localparam logic [LEN_CMP_W-1:0] MAX_COLS_V = LEN_CMP_W'(MAX_COLS);
  // Last column when the line length is clamped to the store depth.
  localparam logic [COL_W-1:0] MAX_LAST = COL_W'(MAX_COLS - 1);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SHIFT = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [COL_W-1:0]  line_length_r, line_length_nxt;
  logic [COL_W-1:0]  cursor_r, cursor_nxt;
  logic [COL_W-1:0]  text_len_r, text_len_nxt;
  logic              done_r, done_nxt;

  // Per-request working registers.
  logic [COL_W-1:0]  ptr_r, ptr_nxt;          // next column to read during a shift
  logic              is_bs_r, is_bs_nxt;      // shift came from Backspace
  logic              wr_pend_r, wr_pend_nxt;  // read data must be written back
  logic [COL_W-1:0]  wr_addr_r, wr_addr_nxt;
  logic              use_mem_r, use_mem_nxt;  // read result comes from the store
  logic              edited_r, edited_nxt;
  logic [CHAR_W-1:0] rch_r, rch_nxt;

  // Result register.
  logic              out_valid_r, out_valid_nxt;
  logic [COL_W-1:0]  out_cursor_r, out_cursor_nxt;
  logic [COL_W-1:0]  out_text_r, out_text_nxt;
  logic              out_done_r, out_done_nxt;
  logic              out_edited_r, out_edited_nxt;
  logic [CHAR_W-1:0] out_rch_r, out_rch_nxt;

  // Line store port signals.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [CHAR_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [CHAR_W-1:0] ram_rdata;

  logic [COL_W-1:0]  last_col;
  logic [COL_W-1:0]  end_col;
  logic              in_take;
  logic              cfg_take;
  logic              out_free;

  // Last usable column: a zero length acts as one column, and lengths past
  // the store depth are clamped to it.
  always_comb begin
    if (line_length_r == '0) begin
      last_col = '0;
    end else if ({2'b00, line_length_r} > MAX_COLS_V) begin
      last_col = MAX_LAST;
    end else begin
      last_col = line_length_r - COL_W'(1);
    end
  end

  // End key target: just past the text, but never beyond the last column.
  assign end_col = (text_len_r < last_col) ? text_len_r : last_col;

  assign cfg_ready = (state_r == ST_IDLE);
  assign in_stall  = (state_r != ST_IDLE) || cfg_valid;
  assign cfg_take  = cfg_valid && cfg_ready;
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt       = state_r;
    line_length_nxt = line_length_r;
    cursor_nxt      = cursor_r;
    text_len_nxt    = text_len_r;
    done_nxt        = done_r;
    ptr_nxt         = ptr_r;
    is_bs_nxt       = is_bs_r;
    wr_pend_nxt     = wr_pend_r;
    wr_addr_nxt     = wr_addr_r;
    use_mem_nxt     = use_mem_r;
    edited_nxt      = edited_r;
    rch_nxt         = rch_r;
    out_valid_nxt   = out_valid_r && out_stall;
    out_cursor_nxt  = out_cursor_r;
    out_text_nxt    = out_text_r;
    out_done_nxt    = out_done_r;
    out_edited_nxt  = out_edited_r;
    out_rch_nxt     = out_rch_r;
    ram_we          = 1'b0;
    ram_waddr       = AW'(cursor_r);
    ram_wdata       = in_key_code;
    ram_raddr       = AW'(in_read_index);

    case (state_r)
      ST_IDLE: begin
        if (cfg_take) begin
          // A new line length starts a fresh, empty line.
          line_length_nxt = cfg_line_length;
          cursor_nxt      = '0;
          text_len_nxt    = '0;
          done_nxt        = 1'b0;
        end else if (in_take) begin
          edited_nxt = 1'b0;
          rch_nxt    = CH_NONE;
          state_nxt  = ST_FIN;
          case (in_func)
            FN_CHAR: begin
              if (!done_r) begin
                if (in_key_code == KEY_ENTER) begin
                  done_nxt = 1'b1;
                end else if (in_key_code == KEY_HOME) begin
                  cursor_nxt = '0;
                end else if (in_key_code == KEY_END) begin
                  cursor_nxt = end_col;
                end else if (in_key_code == KEY_BS) begin
                  if (cursor_r != '0 && text_len_r != '0) begin
                    edited_nxt  = 1'b1;
                    is_bs_nxt   = 1'b1;
                    ptr_nxt     = cursor_r;
                    wr_pend_nxt = 1'b0;
                    state_nxt   = ST_SHIFT;
                  end
                end else if (in_key_code == KEY_DEL) begin
                  if (cursor_r < text_len_r) begin
                    edited_nxt  = 1'b1;
                    is_bs_nxt   = 1'b0;
                    ptr_nxt     = cursor_r + COL_W'(1);
                    wr_pend_nxt = 1'b0;
                    state_nxt   = ST_SHIFT;
                  end
                end else if (in_key_code inside {[CH_FIRST:CH_LAST]}) begin
                  // Overwrite the cell under the cursor. The cursor never
                  // passes the text end, so the text grows only when the
                  // cursor sits right at it.
                  ram_we     = 1'b1;
                  edited_nxt = 1'b1;
                  if (cursor_r == text_len_r) begin
                    text_len_nxt = text_len_r + COL_W'(1);
                  end
                  if (cursor_r < last_col) begin
                    cursor_nxt = cursor_r + COL_W'(1);
                  end
                end
              end
            end
            FN_SPECIAL: begin
              if (!done_r) begin
                case (in_key_code)
                  SP_HOME: cursor_nxt = '0;
                  SP_END:  cursor_nxt = end_col;
                  SP_LEFT: begin
                    if (cursor_r != '0) begin
                      cursor_nxt = cursor_r - COL_W'(1);
                    end
                  end
                  SP_RIGHT: begin
                    if (cursor_r < text_len_r && cursor_r < last_col) begin
                      cursor_nxt = cursor_r + COL_W'(1);
                    end
                  end
                  default: begin
                  end
                endcase
              end
            end
            FN_CLEAR: begin
              cursor_nxt   = '0;
              text_len_nxt = '0;
              done_nxt     = 1'b0;
            end
            default: begin
              // Read: columns past the store read as zero, columns past the
              // text as spaces, and the rest come from the store.
              state_nxt   = ST_READ;
              use_mem_nxt = 1'b0;
              if ({2'b00, in_read_index} < MAX_COLS_V) begin
                rch_nxt = CH_SPACE;
                if (in_read_index < text_len_r) begin
                  use_mem_nxt = 1'b1;
                end
              end
            end
          endcase
        end
      end

      ST_SHIFT: begin
        // Read column ptr while writing the previous column's data one to
        // the left; read and write addresses never coincide.
        ram_raddr = AW'(ptr_r);
        if (wr_pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(wr_addr_r);
          ram_wdata = ram_rdata;
        end
        if (ptr_r < text_len_r) begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = ptr_r - COL_W'(1);
          ptr_nxt     = ptr_r + COL_W'(1);
        end else begin
          // The last pending write, if any, lands in this cycle.
          wr_pend_nxt  = 1'b0;
          text_len_nxt = text_len_r - COL_W'(1);
          if (is_bs_r) begin
            cursor_nxt = cursor_r - COL_W'(1);
          end
          state_nxt = ST_FIN;
        end
      end

      ST_READ: begin
        if (use_mem_r) begin
          rch_nxt = ram_rdata;
        end
        state_nxt = ST_FIN;
      end

      default: begin
        // Hand the result over as soon as the result register is free.
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_cursor_nxt = cursor_r;
          out_text_nxt   = text_len_r;
          out_done_nxt   = done_r;
          out_edited_nxt = edited_r;
          out_rch_nxt    = rch_r;
          state_nxt      = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      line_length_r <= LINE_LEN_RST;
      cursor_r      <= '0;
      text_len_r    <= '0;
      done_r        <= 1'b0;
      wr_pend_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      line_length_r <= line_length_nxt;
      cursor_r      <= cursor_nxt;
      text_len_r    <= text_len_nxt;
      done_r        <= done_nxt;
      wr_pend_r     <= wr_pend_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r        <= ptr_nxt;
    is_bs_r      <= is_bs_nxt;
    wr_addr_r    <= wr_addr_nxt;
    use_mem_r    <= use_mem_nxt;
    edited_r     <= edited_nxt;
    rch_r        <= rch_nxt;
    out_cursor_r <= out_cursor_nxt;
    out_text_r   <= out_text_nxt;
    out_done_r   <= out_done_nxt;
    out_edited_r <= out_edited_nxt;
    out_rch_r    <= out_rch_nxt;
  end

  tleb_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (MAX_COLS)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_cursor_col = out_cursor_r;
  assign out_text_count = out_text_r;
  assign out_line_done  = out_done_r;
  assign out_edited     = out_edited_r;
  assign out_read_char  = out_rch_r;

  // The cursor never runs past the end of the text.
  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= text_len_r)
    else $error("cursor beyond text end");

  // The text never outgrows the usable columns.
  a_text_fits: assert property (@(posedge clk) disable iff (!rst_n)
    text_len_r <= last_col + COL_W'(1))
    else $error("text longer than line");

  // Shift write-back stays inside the text.
  a_shift_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SHIFT && wr_pend_r) |-> (wr_addr_r < text_len_r))
    else $error("shift writes outside the text");

  // A finished request with a free result register yields a result next cycle.
  a_fin_delivers: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_free) |=> (out_valid_r && state_r == ST_IDLE))
    else $error("result not delivered");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the terminal line edit buffer top level.
module tb_top;
  import tleb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Clock period, reset length and the run limits. The slowest correct run is
  // every request a Backspace over a full 2047-column line, plus the longest
  // stall bursts on both sides. Roughly 330 requests of that kind take under 8.4 ms.
  // The watchdog allows several times that.
  localparam int  CLK_HALF_NS  = 6;
  localparam int  RST_CYCLES   = 5;
  localparam int  HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int  TAIL_CYCLES  = 2100;  // longest shift of the line store plus margin
  localparam int  MAX_REPORTS  = 10;
  localparam real WATCHDOG_NS  = 40_000_000.0;

  // One result of the block, in the order of its result ports.
  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [COL_W-1:0]  text_count;
    logic              line_done;
    logic              edited;
    logic [CHAR_W-1:0] read_char;
  } line_status_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_func;
  logic [CHAR_W-1:0] in_key_code;
  logic [COL_W-1:0]  in_read_index;
  logic              out_valid;
  logic              out_stall;
  logic [COL_W-1:0]  out_cursor_col;
  logic [COL_W-1:0]  out_text_count;
  logic              out_line_done;
  logic              out_edited;
  logic [CHAR_W-1:0] out_read_char;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [COL_W-1:0]  cfg_line_length;

  terminal_line_edit_buffer_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_func        (in_func),
    .in_key_code    (in_key_code),
    .in_read_index  (in_read_index),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_cursor_col (out_cursor_col),
    .out_text_count (out_text_count),
    .out_line_done  (out_line_done),
    .out_edited     (out_edited),
    .out_read_char  (out_read_char),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_line_length(cfg_line_length)
  );

  // Line editor state as the testbench predicts it. The cells are kept as
  // spaces beyond the text, which is how the block must make them read back.
  logic [CHAR_W-1:0] line_store [MAX_COLS_DEF];
  int                cursor_now;
  int                text_len_now;
  logic              done_now;
  int                cfg_cols;

  line_status_t expected_status_q[$];
  int           err_count;

  // Shared controls: idle_on enables random gaps and stall bursts, hold_req
  // asks the result side for one long hold-off and clears itself when done.
  bit idle_on;
  bit hold_req;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // The watchdog ends a run that hangs, for instance on a lost result.
  initial begin
    #(WATCHDOG_NS);
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // A length of zero behaves as a single column; the 11-bit register can never
  // exceed the default line depth.
  function automatic int usable_cols();
    if (cfg_cols == 0) return 1;
    if (cfg_cols > MAX_COLS_DEF) return MAX_COLS_DEF;
    return cfg_cols;
  endfunction

  function automatic void start_new_line();
    foreach (line_store[c]) line_store[c] = CH_SPACE;
    cursor_now   = 0;
    text_len_now = 0;
    done_now     = 1'b0;
  endfunction

  function automatic int end_column();
    int last;
    last = usable_cols() - 1;
    return (text_len_now < last) ? text_len_now : last;
  endfunction

  // Applies one keystroke to the predicted line and returns the status the
  // block must report for it.
  function automatic line_status_t apply_keystroke(input logic [1:0] fn,
                                                   input logic [CHAR_W-1:0] key,
                                                   input logic [COL_W-1:0] col);
    line_status_t st;
    int           last;
    int           i;
    st   = '0;
    last = usable_cols() - 1;
    if (fn == FN_CHAR && !done_now) begin
      if (key == KEY_ENTER) begin
        done_now = 1'b1;
      end else if (key == KEY_HOME) begin
        cursor_now = 0;
      end else if (key == KEY_END) begin
        cursor_now = end_column();
      end else if (key == KEY_BS) begin
        // Backspace closes the gap left of the cursor and pads the old last cell.
        if (cursor_now > 0 && text_len_now > 0) begin
          for (i = cursor_now; i < text_len_now; i++) line_store[i-1] = line_store[i];
          line_store[text_len_now-1] = CH_SPACE;
          cursor_now--;
          text_len_now--;
          st.edited = 1'b1;
        end
      end else if (key == KEY_DEL) begin
        if (cursor_now < text_len_now) begin
          for (i = cursor_now + 1; i < text_len_now; i++) line_store[i-1] = line_store[i];
          line_store[text_len_now-1] = CH_SPACE;
          text_len_now--;
          st.edited = 1'b1;
        end
      end else if (key >= CH_FIRST && key <= CH_LAST) begin
        // Overwrite always counts as an edit, even with the same byte.
        line_store[cursor_now] = key;
        if (text_len_now < cursor_now + 1) text_len_now = cursor_now + 1;
        if (cursor_now < last) cursor_now++;
        st.edited = 1'b1;
      end
    end else if (fn == FN_SPECIAL && !done_now) begin
      if (key == SP_HOME) begin
        cursor_now = 0;
      end else if (key == SP_END) begin
        cursor_now = end_column();
      end else if (key == SP_LEFT) begin
        if (cursor_now > 0) cursor_now--;
      end else if (key == SP_RIGHT) begin
        if (cursor_now < text_len_now && cursor_now < last) cursor_now++;
      end
    end else if (fn == FN_CLEAR) begin
      start_new_line();
    end else if (fn == FN_READ) begin
      if (col < MAX_COLS_DEF) st.read_char = line_store[col];
    end
    st.cursor_col = COL_W'(cursor_now);
    st.text_count = COL_W'(text_len_now);
    st.line_done  = done_now;
    return st;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: stall generation and checking
  // ---------------------------------------------------------------------------

  // Random stall bursts while idling is on. A hold-off request overrides them
  // and keeps the result channel stalled through one long hold-off, which
  // fills the block and pushes back on the request channel.
  initial begin : result_stall_gen
    int burst;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        burst = $urandom_range(1, 8);
        out_stall <= 1'b1;
        repeat (burst) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every accepted result is matched against the oldest prediction. Outputs
  // are sampled at the edge, before any update the edge itself causes.
  always @(posedge clk) begin : status_check
    line_status_t got;
    line_status_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_cursor_col, out_text_count, out_line_done, out_edited, out_read_char};
      if (expected_status_q.size() == 0) begin
        err_count++;
        if (err_count <= MAX_REPORTS)
          $display("%0t: result with none pending: cursor %0d count %0d done %b edited %b char %h",
                   $realtime, got.cursor_col, got.text_count, got.line_done, got.edited,
                   got.read_char);
      end else begin
        want = expected_status_q.pop_front();
        if (got.cursor_col !== want.cursor_col || got.text_count !== want.text_count ||
            got.line_done !== want.line_done || got.edited !== want.edited ||
            got.read_char !== want.read_char) begin
          err_count++;
          if (err_count <= MAX_REPORTS) begin
            $display("%0t: status mismatch", $realtime);
            $display("  expected: cursor %0d count %0d done %b edited %b char %h",
                     want.cursor_col, want.text_count, want.line_done, want.edited,
                     want.read_char);
            $display("  actual:   cursor %0d count %0d done %b edited %b char %h",
                     got.cursor_col, got.text_count, got.line_done, got.edited, got.read_char);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------

  // Sends one keystroke request. Valid stays high between back-to-back
  // requests; it only drops for a random gap or when the sender pauses.
  // The prediction is made once the request has been accepted.
  task automatic send_keystroke(input logic [1:0] fn, input logic [CHAR_W-1:0] key,
                                input logic [COL_W-1:0] col);
    int gap;
    if (idle_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= fn;
    in_key_code   <= key;
    in_read_index <= col;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_status_q.push_back(apply_keystroke(fn, key, col));
  endtask

  // The sender stops offering and waits until every pending result is back.
  task automatic wait_line_idle();
    in_valid <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk);
  endtask

  // A length write starts a new empty line, so it is only issued while idle.
  task automatic write_line_length(input logic [COL_W-1:0] len);
    wait_line_idle();
    @(posedge clk);
    cfg_valid       <= 1'b1;
    cfg_line_length <= len;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    cfg_cols = len;
    start_new_line();
  endtask

  // Types a short word of random printable bytes.
  task automatic type_chars(input int n);
    repeat (n) send_keystroke(FN_CHAR, CHAR_W'($urandom_range(CH_FIRST, CH_LAST)),
                              COL_W'($urandom_range(0, 2047)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // After reset the line is empty and reads back as spaces at both ends.
  task automatic test_power_on_state();
    send_keystroke(FN_READ, 8'hFF, 11'd0);
    send_keystroke(FN_READ, 8'h00, 11'd2047);
  endtask

  // Printable extremes, cursor keys at their bounds, Backspace at column zero,
  // Delete, and the codes that must be ignored (redraw among them).
  task automatic test_editing_keys();
    send_keystroke(FN_CHAR, CH_FIRST, 11'h555);
    send_keystroke(FN_CHAR, CH_LAST, 11'h2AA);
    send_keystroke(FN_CHAR, 8'h62, 11'd0);
    send_keystroke(FN_CHAR, KEY_HOME, 11'd0);
    send_keystroke(FN_CHAR, KEY_BS, 11'd0);
    send_keystroke(FN_CHAR, KEY_DEL, 11'd0);
    send_keystroke(FN_SPECIAL, SP_LEFT, 11'd0);
    send_keystroke(FN_SPECIAL, SP_RIGHT, 11'd0);
    send_keystroke(FN_SPECIAL, SP_END, 11'd0);
    send_keystroke(FN_SPECIAL, SP_RIGHT, 11'd0);
    send_keystroke(FN_CHAR, 8'd12, 11'd0);
    send_keystroke(FN_CHAR, 8'hFF, 11'd0);
    send_keystroke(FN_SPECIAL, 8'd4, 11'd0);
    send_keystroke(FN_SPECIAL, 8'hFF, 11'd0);
    send_keystroke(FN_CHAR, KEY_BS, 11'd0);
    send_keystroke(FN_READ, 8'd0, 11'd0);
  endtask

  // Once Enter is taken, keys change nothing, reads still work and a
  // clear starts editing again.
  task automatic test_enter_lock();
    send_keystroke(FN_CHAR, KEY_ENTER, 11'd0);
    send_keystroke(FN_CHAR, 8'h7A, 11'd0);
    send_keystroke(FN_SPECIAL, SP_HOME, 11'd0);
    send_keystroke(FN_READ, 8'd0, 11'd0);
    send_keystroke(FN_CLEAR, 8'd0, 11'd0);
  endtask

  // Zero length acts as one column; on a three-column line the cursor stops at
  // the last column and End goes to the last column, not past it.
  task automatic test_short_lines();
    write_line_length(11'd0);
    type_chars(2);
    send_keystroke(FN_CHAR, KEY_END, 11'd0);
    write_line_length(11'd3);
    type_chars(4);
    send_keystroke(FN_SPECIAL, SP_END, 11'd0);
    send_keystroke(FN_CHAR, KEY_BS, 11'd0);
  endtask

  // Mostly well-formed editing with random content; a few percent is noise
  // made of unlisted codes with random bits everywhere.
  task automatic test_random_editing(input logic [COL_W-1:0] len, input int n,
                                     input bit with_idle);
    int               sel;
    logic [1:0]       fn;
    logic [CHAR_W-1:0] key;
    logic [COL_W-1:0] col;
    int               near;
    write_line_length(len);
    idle_on = with_idle;
    repeat (n) begin
      sel = $urandom_range(0, 99);
      fn  = FN_CHAR;
      key = CHAR_W'($urandom_range(CH_FIRST, CH_LAST));
      col = COL_W'($urandom_range(0, 2047));
      if (sel < 50) begin
        fn = FN_CHAR;
      end else if (sel < 58) begin
        key = KEY_BS;
      end else if (sel < 64) begin
        key = KEY_DEL;
      end else if (sel < 67) begin
        key = $urandom_range(0, 1) ? KEY_HOME : KEY_END;
      end else if (sel < 79) begin
        fn  = FN_SPECIAL;
        key = CHAR_W'($urandom_range(0, 3));
      end else if (sel < 81) begin
        key = KEY_ENTER;
      end else if (sel < 84) begin
        fn  = FN_CLEAR;
        key = CHAR_W'($urandom_range(0, 255));
      end else if (sel < 95) begin
        fn = FN_READ;
        key = CHAR_W'($urandom_range(0, 255));
        if ($urandom_range(0, 2) != 0) begin
          near = $urandom_range(0, text_len_now + 2);
          col  = COL_W'((near > 2047) ? 2047 : near);
        end
      end else begin
        fn  = $urandom_range(0, 1) ? FN_SPECIAL : FN_CHAR;
        key = CHAR_W'($urandom_range(0, 255));
      end
      send_keystroke(fn, key, col);
    end
  endtask

  // The result side holds off for a long stretch while requests keep coming,
  // so the block fills and stalls its input. Afterwards the sender pauses
  // until every pending result has come back.
  task automatic test_full_backpressure();
    idle_on  = 1'b0;
    hold_req = 1'b1;
    type_chars(6);
    send_keystroke(FN_CHAR, KEY_HOME, 11'd0);
    send_keystroke(FN_CHAR, KEY_DEL, 11'd0);
    send_keystroke(FN_SPECIAL, SP_END, 11'd0);
    send_keystroke(FN_CHAR, KEY_BS, 11'd0);
    send_keystroke(FN_READ, 8'd0, 11'd1);
    send_keystroke(FN_READ, 8'd0, 11'd3);
    wait (!hold_req);
    wait_line_idle();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin : run_tests
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_func         = FN_CHAR;
    in_key_code     = '0;
    in_read_index   = '0;
    cfg_valid       = 1'b0;
    cfg_line_length = LINE_LEN_RST;
    err_count       = 0;
    idle_on         = 1'b1;
    hold_req        = 1'b0;
    cfg_cols        = LINE_LEN_RST;
    start_new_line();

    repeat (RST_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_power_on_state();
    test_editing_keys();
    test_enter_lock();
    test_short_lines();
    test_random_editing(LINE_LEN_RST, 70, 1'b1);
    test_random_editing(11'd2047, 60, 1'b1);
    test_full_backpressure();
    test_random_editing(11'd7, 55, 1'b1);
    test_random_editing(11'd1, 25, 1'b1);
    // The closing stretch runs without any idling on either side.
    test_random_editing(11'd33, 60, 1'b0);

    wait_line_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    err_count += expected_status_q.size();
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/tleb_pkg.sv
src/tleb_ram.sv
src/terminal_line_edit_buffer_top.sv
dv/tb_top.sv
